>>> rtl/core/apd_pkg.sv
// shared types and constants for the altitude pid block with deadband
// register indexes, configuration bundle and internal result structs
// no dependencies

package apd_pkg;

    // field widths
    localparam int ALT_W    = 16;
    localparam int THR_W    = 16;
    localparam int ERR_W    = ALT_W + 1;
    localparam int DERR_W   = ERR_W + 1;
    localparam int INTEG_W  = 24;
    localparam int GAIN_W   = 16;
    localparam int DBAND_W  = 15;
    localparam int BIAS_W   = 17;
    localparam int CHG_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // stream payload widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET   = 4'd0,
        REG_DEADBAND = 4'd1,
        REG_GAIN_P   = 4'd2,
        REG_GAIN_I   = 4'd3,
        REG_GAIN_D   = 4'd4,
        REG_INT_MAX  = 4'd5,
        REG_INT_MIN  = 4'd6,
        REG_BIAS     = 4'd7
    } t_reg_idx;

    // configuration bundle
    typedef struct packed {
        logic signed [ALT_W-1:0]   target;
        logic        [DBAND_W-1:0] deadband;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [INTEG_W-1:0] int_max;
        logic signed [INTEG_W-1:0] int_min;
        logic signed [BIAS_W-1:0]  bias;
    } t_cfg;

    // error terms for the control law
    typedef struct packed {
        logic                      active;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERR_W-1:0]  derr;
    } t_err_info;

    // held controller state
    typedef struct packed {
        logic signed [INTEG_W-1:0] integral;
        logic signed [ERR_W-1:0]   prev_err;
    } t_state;

    // one result item
    typedef struct packed {
        logic signed [CHG_W-1:0] change;
        logic        [THR_W-1:0] new_thrust;
        logic                    active;
    } t_result;

endpackage

>>> rtl/core/altitude_pid_with_deadband_unit.sv
// altitude pid with deadband: one result per input transfer, taken from the input
// register in a single pass through the three products into the result register;
// throughput one item per cycle while the result stream does not stall
// integral and previous error update with the result register, for active items only
// synchronous active-low reset clears configuration, state and both valid flags
// depends on apd_pkg, apd_cfg_regs, apd_integ, apd_law

module altitude_pid_with_deadband_unit import apd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // altitude[15:0], current_thrust[31:16]
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // thrust_change[31:0], new_thrust[47:32]
    output logic [M_USER_W-1:0]   o_m_tuser    // active[0]
);

    t_cfg      cfg;
    t_err_info info;
    t_state    state;
    t_result   result;

    logic                    r_in_valid;
    logic signed [ALT_W-1:0] r_altitude;
    logic        [THR_W-1:0] r_thrust;
    logic                    r_out_valid;
    t_result                 r_result;

    logic s_xfer;
    logic fire;

    // handshakes: the result register frees as it is taken
    assign fire        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || fire;
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    apd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    apd_integ u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_altitude (r_altitude),
        .i_update   (fire),
        .o_info     (info),
        .o_state    (state)
    );

    apd_law u_law (
        .i_cfg    (cfg),
        .i_info   (info),
        .i_thrust (r_thrust),
        .o_result (result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_altitude <= i_s_tdata[ALT_W-1:0];
            r_thrust   <= i_s_tdata[ALT_W+THR_W-1:ALT_W];
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_result.new_thrust, r_result.change};
    assign o_m_tuser  = r_result.active;

    // state only moves on an active transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && info.active) |=> $stable(state))
        else $error("controller state changed without an active transfer");

    // an inactive result carries no correction
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[CHG_W-1:0] == '0))
        else $error("inactive result with non-zero thrust change");

    // with ordered limits the stored integral lies inside them
    a_int_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && info.active && (cfg.int_min <= cfg.int_max)) |=>
        ((state.integral <= $past(cfg.int_max)) && (state.integral >= $past(cfg.int_min))))
        else $error("integral outside its clamp");

    // a stalled result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && o_m_tvalid))
        else $error("pending result overwritten");

endmodule

>>> rtl/core/apd_cfg_regs.sv
// configuration register file of the altitude pid block
// depends on apd_pkg

module apd_cfg_regs import apd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode a register write, out-of-range indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET:   n_cfg.target   = i_cfg_data[ALT_W-1:0];
                REG_DEADBAND: n_cfg.deadband = i_cfg_data[DBAND_W-1:0];
                REG_GAIN_P:   n_cfg.gain_p   = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   n_cfg.gain_i   = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   n_cfg.gain_d   = i_cfg_data[GAIN_W-1:0];
                REG_INT_MAX:  n_cfg.int_max  = i_cfg_data[INTEG_W-1:0];
                REG_INT_MIN:  n_cfg.int_min  = i_cfg_data[INTEG_W-1:0];
                REG_BIAS:     n_cfg.bias     = i_cfg_data[BIAS_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/apd_integ.sv
// error, deadband test, clamped integral and held state of the pid block
// depends on apd_pkg

module apd_integ import apd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic signed [ALT_W-1:0] i_altitude,
    input  logic                    i_update,
    output t_err_info               o_info,
    output t_state                  o_state
);

    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;

    logic signed [ERR_W-1:0]   err;
    logic        [ERR_W-1:0]   mag;
    logic                      active;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   lim_max;
    logic signed [INTEG_W:0]   lim_min;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERR_W-1:0]  derr;

    // error to target and deadband test
    assign err    = ERR_W'(i_cfg.target) - ERR_W'(i_altitude);
    assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign active = mag > {{(ERR_W-DBAND_W){1'b0}}, i_cfg.deadband};

    // accumulate and clamp, upper limit checked first
    assign integ_sum = (INTEG_W+1)'(r_integral) + (INTEG_W+1)'(err);
    assign lim_max   = (INTEG_W+1)'(i_cfg.int_max);
    assign lim_min   = (INTEG_W+1)'(i_cfg.int_min);

    always_comb begin
        if (integ_sum > lim_max) begin
            integ = i_cfg.int_max;
        end else if (integ_sum < lim_min) begin
            integ = i_cfg.int_min;
        end else begin
            integ = integ_sum[INTEG_W-1:0];
        end
    end

    // change of error since the last active sample
    assign derr = DERR_W'(err) - DERR_W'(r_prev_err);

    // state moves only on an active transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_update && active) begin
            r_integral <= integ;
            r_prev_err <= err;
        end
    end

    assign o_info.active   = active;
    assign o_info.err      = err;
    assign o_info.integ    = integ;
    assign o_info.derr     = derr;
    assign o_state.integral = r_integral;
    assign o_state.prev_err = r_prev_err;

endmodule

>>> rtl/core/apd_law.sv
// pid control law: products, rounding, bias, saturation and new thrust
// depends on apd_pkg

module apd_law import apd_pkg::*; (
    input  t_cfg             i_cfg,
    input  t_err_info        i_info,
    input  logic [THR_W-1:0] i_thrust,
    output t_result          o_result
);

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + INTEG_W;
    localparam int PD_W  = GAIN_W + DERR_W;
    localparam int SUM_W = PI_W + 1;
    localparam int RND_W = SUM_W - 8;
    localparam int EXT_W = CHG_W + 2;

    logic signed [PP_W-1:0]  p_p;
    logic signed [PI_W-1:0]  p_i;
    logic signed [PD_W-1:0]  p_d;
    logic signed [SUM_W-1:0] sum;
    logic signed [RND_W-1:0] rnd;
    logic signed [EXT_W-1:0] chg_ext;
    logic signed [CHG_W-1:0] chg_sat;
    logic signed [CHG_W-1:0] change;
    logic signed [EXT_W-1:0] nt_ext;
    logic        [THR_W-1:0] nt;

    // three independent products of the q8.8 gains
    assign p_p = PP_W'(i_cfg.gain_p) * PP_W'(i_info.err);
    assign p_i = PI_W'(i_cfg.gain_i) * PI_W'(i_info.integ);
    assign p_d = PD_W'(i_cfg.gain_d) * PD_W'(i_info.derr);

    // round half up then floor by 256
    assign sum = SUM_W'(p_p) + SUM_W'(p_i) + SUM_W'(p_d) + SUM_W'(128);
    assign rnd = sum[SUM_W-1:8];

    assign chg_ext = EXT_W'(rnd) + EXT_W'(i_cfg.bias);

    // saturate to the signed 32-bit range
    always_comb begin
        if (chg_ext[EXT_W-1:CHG_W-1] == '0 || chg_ext[EXT_W-1:CHG_W-1] == '1) begin
            chg_sat = chg_ext[CHG_W-1:0];
        end else if (chg_ext[EXT_W-1]) begin
            chg_sat = {1'b1, {(CHG_W-1){1'b0}}};
        end else begin
            chg_sat = {1'b0, {(CHG_W-1){1'b1}}};
        end
    end

    assign change = i_info.active ? chg_sat : '0;

    // new thrust clipped to the unsigned range
    assign nt_ext = EXT_W'({1'b0, i_thrust}) + EXT_W'(change);

    always_comb begin
        if (nt_ext[EXT_W-1]) begin
            nt = '0;
        end else if (nt_ext[EXT_W-2:THR_W] != '0) begin
            nt = '1;
        end else begin
            nt = nt_ext[THR_W-1:0];
        end
    end

    assign o_result.change     = change;
    assign o_result.new_thrust = nt;
    assign o_result.active     = i_info.active;

endmodule
